### hw/rtl/ps2md_pkg.sv
// Package for the PS/2 mouse packet decoder: event codes, packet descriptor
// type and shared constants. No dependencies.
package ps2md_pkg;

    localparam int AUX_DATA_BIT  = 5;
    localparam int BUTTON_COUNT  = 3;
    localparam int EVENT_SLOTS   = BUTTON_COUNT + 1;  // move plus one per button
    localparam int QUEUE_DEPTH   = 2;

    typedef enum logic [1:0] {
        EVT_MOVE    = 2'd0,
        EVT_PRESS   = 2'd1,
        EVT_RELEASE = 2'd2
    } event_kind_t;

    typedef enum logic [1:0] {
        POS_BUTTONS = 2'd0,
        POS_X       = 2'd1,
        POS_Y       = 2'd2
    } packet_pos_t;

    // One complete packet reduced to the events it causes.
    // pending[0] = move event, pending[i] = button i changed.
    typedef struct packed {
        logic [EVENT_SLOTS-1:0]  pending;
        logic [BUTTON_COUNT-1:0] prev_buttons;
        logic signed [7:0]       move_x;
        logic signed [8:0]       move_y;
    } packet_desc_t;

endpackage

### hw/rtl/ps2md_in_if.sv
// Byte channel of the PS/2 mouse packet decoder: valid/ready plus the
// status and data bytes. Depends on ps2md_pkg only by name convention.
interface ps2md_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] status_byte;
    logic [7:0] data_byte;

    modport source (output valid, output status_byte, output data_byte, input ready);
    modport sink   (input valid, input status_byte, input data_byte, output ready);
endinterface

### hw/rtl/ps2md_out_if.sv
// Event channel of the PS/2 mouse packet decoder: valid/ready plus the
// event fields. Depends on ps2md_pkg for the event code type.
interface ps2md_out_if
    import ps2md_pkg::*;
;
    logic              valid;
    logic              ready;
    event_kind_t       event_kind;
    logic signed [7:0] move_x;
    logic signed [8:0] move_y;
    logic [1:0]        button_number;
    logic              last_event;

    modport source (output valid, output event_kind, output move_x, output move_y,
                    output button_number, output last_event, input ready);
    modport sink   (input valid, input event_kind, input move_x, input move_y,
                    input button_number, input last_event, output ready);
endinterface

### hw/rtl/ps2md_front.sv
// Front end: filters auxiliary bytes, assembles three-byte packets and
// turns each complete packet that causes an event into an event descriptor. Uses ps2md_pkg.
module ps2md_front
    import ps2md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ps2md_in_if.sink     byte_ch,
    input  logic         queue_full,
    output logic         push,
    output packet_desc_t push_desc
);

    packet_pos_t              pos_reg, pos_next;
    logic [BUTTON_COUNT-1:0]  buttons_reg, buttons_next;
    logic [7:0]               x_reg, x_next;
    logic [BUTTON_COUNT-1:0]  prev_buttons_reg, prev_buttons_next;
    logic                     take;
    logic                     any_move;

    assign byte_ch.ready = !queue_full;
    assign take = byte_ch.valid && byte_ch.ready && byte_ch.status_byte[AUX_DATA_BIT];
    assign any_move = (x_reg != 8'd0) || (byte_ch.data_byte != 8'd0);

    always_comb
    begin
        pos_next          = pos_reg;
        buttons_next      = buttons_reg;
        x_next            = x_reg;
        prev_buttons_next = prev_buttons_reg;
        push              = 1'b0;

        push_desc.pending      = {buttons_reg ^ prev_buttons_reg, any_move};
        push_desc.prev_buttons = prev_buttons_reg;
        push_desc.move_x       = $signed(x_reg);
        // negation of the signed Y byte, widened to 9 bits
        push_desc.move_y       = 9'sd0 - $signed({byte_ch.data_byte[7], byte_ch.data_byte});

        if (take)
        begin
            case (pos_reg)
                POS_BUTTONS:
                begin
                    buttons_next = byte_ch.data_byte[BUTTON_COUNT-1:0];
                    pos_next     = POS_X;
                end
                POS_X:
                begin
                    x_next   = byte_ch.data_byte;
                    pos_next = POS_Y;
                end
                POS_Y:
                begin
                    push              = (push_desc.pending != '0);
                    prev_buttons_next = buttons_reg;
                    pos_next          = POS_BUTTONS;
                end
                default:
                begin
                    pos_next = POS_BUTTONS;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg          <= POS_BUTTONS;
            prev_buttons_reg <= '0;
        end
        else
        begin
            pos_reg          <= pos_next;
            prev_buttons_reg <= prev_buttons_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buttons_reg <= buttons_next;
        x_reg       <= x_next;
    end

endmodule

### hw/rtl/ps2md_queue.sv
// Small register FIFO of packet descriptors between front and back end.
// Uses ps2md_pkg for the descriptor type and depth.
module ps2md_queue
    import ps2md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  packet_desc_t push_desc,
    output logic         full,
    input  logic         pop,
    output logic         not_empty,
    output packet_desc_t head_desc
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    packet_desc_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_desc = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

### hw/rtl/ps2md_back.sv
// Back end: expands one packet descriptor into move/button events, one per
// cycle into a registered output stage while that stage is free. Uses ps2md_pkg.
module ps2md_back
    import ps2md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         desc_valid,
    input  packet_desc_t desc,
    output logic         pop,
    ps2md_out_if.source  event_ch
);

    packet_desc_t            cur_reg;
    logic                    cur_valid_reg;
    logic [EVENT_SLOTS-1:0]  sel;
    logic [EVENT_SLOTS-1:0]  remaining;
    logic                    out_free;
    logic                    emit;

    logic                    out_valid_reg;
    event_kind_t             kind_reg, kind_next;
    logic signed [7:0]       x_reg, x_next;
    logic signed [8:0]       y_reg, y_next;
    logic [1:0]              button_reg, button_next;
    logic                    last_reg;

    // lowest pending slot first: move, then buttons 1..3
    assign sel       = cur_reg.pending & (~cur_reg.pending + EVENT_SLOTS'(1));
    assign remaining = cur_reg.pending & ~sel;
    assign out_free  = !out_valid_reg || event_ch.ready;
    assign emit      = cur_valid_reg && out_free;
    assign pop       = desc_valid && (!cur_valid_reg || (emit && remaining == '0));

    always_comb
    begin
        kind_next   = EVT_MOVE;
        x_next      = 8'sd0;
        y_next      = 9'sd0;
        button_next = 2'd0;
        if (sel[0])
        begin
            x_next = cur_reg.move_x;
            y_next = cur_reg.move_y;
        end
        else
        begin
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                if (sel[i+1])
                begin
                    kind_next   = cur_reg.prev_buttons[i] ? EVT_RELEASE : EVT_PRESS;
                    button_next = 2'(i + 1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (emit && remaining == '0)
                cur_valid_reg <= 1'b0;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (event_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= desc;
        else if (emit)
            cur_reg.pending <= remaining;

        if (emit)
        begin
            kind_reg   <= kind_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            button_reg <= button_next;
            last_reg   <= (remaining == '0);
        end
    end

    assign event_ch.valid         = out_valid_reg;
    assign event_ch.event_kind    = kind_reg;
    assign event_ch.move_x        = x_reg;
    assign event_ch.move_y        = y_reg;
    assign event_ch.button_number = button_reg;
    assign event_ch.last_event    = last_reg;

endmodule

### hw/rtl/ps2md_mouse_packet_decoder.sv
// Top level of the PS/2 mouse packet decoder: front end, descriptor queue
// and back end. Uses ps2md_pkg, ps2md_in_if and ps2md_out_if.
//
// Usage:
//   byte_ch  : one transfer per controller read (status byte, data byte).
//              Bytes without the auxiliary-data status bit are dropped.
//              Every third kept byte completes a packet.
//   event_ch : move and button press/release events of each packet, move
//              first, then buttons 1..3; last_event marks the packet's end.
// Throughput: byte_ch takes one byte per cycle while the two-entry
//   descriptor queue has room; the back end sends one event per cycle while
//   event_ch is ready, so a packet (three bytes) produces up to four events.
// Path: the first event of a packet is valid once the transfer of its third
//   byte has passed the queue write, expansion register and output register.
// Reset: packet position and stored button state clear; no event pending.
// Stall: while event_ch is not ready the output register holds its event;
//   the queue absorbs up to two further packets, then byte_ch drops ready.
module ps2_mouse_packet_decoder
    import ps2md_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    ps2md_in_if.sink     byte_ch,
    ps2md_out_if.source  event_ch
);

    logic         push;
    packet_desc_t push_desc;
    logic         queue_full;
    logic         pop;
    logic         queue_not_empty;
    packet_desc_t head_desc;

    ps2md_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .queue_full (queue_full),
        .push       (push),
        .push_desc  (push_desc)
    );

    ps2md_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (queue_not_empty),
        .head_desc (head_desc)
    );

    ps2md_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (queue_not_empty),
        .desc       (head_desc),
        .pop        (pop),
        .event_ch   (event_ch)
    );

endmodule

### bench/tb_ps2_mouse_packet_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for ps2_mouse_packet_decoder: drives status/data bytes,
// predicts the move and button events of each packet and checks every event.
// Needs ps2md_pkg, ps2md_in_if, ps2md_out_if and the decoder RTL.
module tb_ps2_mouse_packet_decoder
    import ps2md_pkg::*;
;

    localparam int CLK_PERIOD  = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_BYTES = 360;
    localparam logic [7:0] AUX_MASK = 8'h01 << AUX_DATA_BIT;

    typedef struct {
        event_kind_t       kind;
        logic signed [7:0] dx;
        logic signed [8:0] dy;
        logic [1:0]        button;
        logic              last;
    } mouse_event_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ps2md_in_if  byte_ch ();
    ps2md_out_if event_ch ();

    ps2_mouse_packet_decoder dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_ch  (byte_ch),
        .event_ch (event_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // decoder state as seen by the predictor
    packet_pos_t pkt_pos      = POS_BUTTONS;
    logic [7:0]  pkt_flags    = 8'h00;
    logic [7:0]  pkt_dx       = 8'h00;
    logic [2:0]  held_buttons = 3'b000;

    mouse_event_t pending_events[$];
    int mismatch_count = 0;
    int burst_left = 0;
    int cycle_count = 0;

    // Updates the packet state with one accepted byte and queues the events
    // a completed packet causes.
    task automatic decode_byte(input logic [7:0] status, input logic [7:0] data);
        mouse_event_t ev;
        mouse_event_t evs[$];
        logic [2:0] now_buttons;
        int i;
        if (status[AUX_DATA_BIT])
        begin
            case (pkt_pos)
                POS_BUTTONS:
                begin
                    pkt_flags = data;
                    pkt_pos = POS_X;
                end
                POS_X:
                begin
                    pkt_dx = data;
                    pkt_pos = POS_Y;
                end
                default:
                begin
                    pkt_pos = POS_BUTTONS;
                    if (pkt_dx != 8'h00 || data != 8'h00)
                    begin
                        ev.kind = EVT_MOVE;
                        ev.dx = pkt_dx;
                        ev.dy = 9'sd0 - $signed({data[7], data});
                        ev.button = 2'd0;
                        ev.last = 1'b0;
                        evs.push_back(ev);
                    end
                    // overflow and sign flags in bits 7:3 play no part
                    now_buttons = pkt_flags[2:0];
                    for (i = 0; i < BUTTON_COUNT; i++)
                    begin
                        if (now_buttons[i] != held_buttons[i])
                        begin
                            ev.kind = held_buttons[i] ? EVT_RELEASE : EVT_PRESS;
                            ev.dx = 8'sd0;
                            ev.dy = 9'sd0;
                            ev.button = 2'(i + 1);
                            ev.last = 1'b0;
                            evs.push_back(ev);
                        end
                    end
                    held_buttons = now_buttons;
                    if (evs.size() > 0)
                        evs[evs.size() - 1].last = 1'b1;
                    foreach (evs[k])
                        pending_events.push_back(evs[k]);
                end
            endcase
        end
    endtask

    task automatic compare_event();
        mouse_event_t exp;
        if (pending_events.size() == 0)
        begin
            $error("unexpected event: kind %0d button %0d", event_ch.event_kind,
                   event_ch.button_number);
            mismatch_count++;
        end
        else
        begin
            exp = pending_events.pop_front();
            if (event_ch.event_kind !== exp.kind)
            begin
                $error("event_kind expected %0d got %0d", exp.kind, event_ch.event_kind);
                mismatch_count++;
            end
            if (event_ch.move_x !== exp.dx)
            begin
                $error("move_x expected %0d got %0d", exp.dx, event_ch.move_x);
                mismatch_count++;
            end
            if (event_ch.move_y !== exp.dy)
            begin
                $error("move_y expected %0d got %0d", exp.dy, event_ch.move_y);
                mismatch_count++;
            end
            if (event_ch.button_number !== exp.button)
            begin
                $error("button_number expected %0d got %0d", exp.button,
                       event_ch.button_number);
                mismatch_count++;
            end
            if (event_ch.last_event !== exp.last)
            begin
                $error("last_event expected %0d got %0d", exp.last, event_ch.last_event);
                mismatch_count++;
            end
        end
    endtask

    // event sink: checks each transfer, ready follows a rotating mask that is
    // reloaded at random from four patterns (always ready, random, sparse, one in sixteen)
    initial
    begin : event_sink
        logic [15:0] stall_mask;
        int mask_age;
        stall_mask = 16'hFFFF;
        mask_age = 0;
        event_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && event_ch.valid && event_ch.ready)
                compare_event();
            if (mask_age == 47)
            begin
                mask_age = 0;
                case ($urandom_range(0, 3))
                    0: stall_mask = 16'hFFFF;
                    1: stall_mask = 16'($urandom) | 16'h0001;
                    2: stall_mask = 16'h8888;
                    default: stall_mask = 16'h0001;
                endcase
            end
            else
                mask_age++;
            event_ch.ready <= rst_n & stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ps2_mouse_packet_decoder verification failed");
            $finish;
        end
    end

    // One byte transfer; the sender goes in bursts with idle gaps between.
    task automatic send_byte(input logic [7:0] status, input logic [7:0] data);
        if (burst_left == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
        end
        burst_left--;
        byte_ch.valid <= 1'b1;
        byte_ch.status_byte <= status;
        byte_ch.data_byte <= data;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        decode_byte(status, data);
    endtask

    // status with the aux bit cleared: the byte must be dropped
    task automatic send_noise();
        send_byte(8'($urandom) & ~AUX_MASK, 8'($urandom));
    endtask

    task automatic send_packet(input logic [7:0] flags, input logic [7:0] dx,
                               input logic [7:0] dy, input int noise_pct);
        logic [7:0] bytes[3];
        bytes = '{flags, dx, dy};
        foreach (bytes[k])
        begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise();
            send_byte(8'($urandom) | AUX_MASK, bytes[k]);
        end
    endtask

    task automatic wait_for_drain();
        byte_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        burst_left = 0;
    endtask

    // zero often, extremes sometimes, otherwise anything
    function automatic logic [7:0] pick_motion();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h00;
            3: return 8'h80;
            4: return 8'h7F;
            5: return 8'hFF;
            6: return 8'h01;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_ignored_bytes();
        send_byte(8'h00, 8'hFF);
        send_byte(8'hDF, 8'h00);
    endtask

    task automatic test_move_extremes();
        send_packet(8'hF8, 8'h80, 8'h80, 0);  // flags set, buttons up: move only
        send_packet(8'h00, 8'hFF, 8'h01, 0);
    endtask

    task automatic test_buttons();
        send_packet(8'h07, 8'h7F, 8'h7F, 0);  // move plus three presses
        send_packet(8'hFF, 8'h00, 8'h00, 0);  // nothing changed: no events
        send_byte(AUX_MASK, 8'h02);
        send_byte(8'h1F, 8'hAA);              // dropped in mid-packet
        send_byte(AUX_MASK, 8'h00);
        send_byte(AUX_MASK, 8'h00);
        send_packet(8'h00, 8'h00, 8'h01, 0);
        send_packet(8'h05, 8'h00, 8'h00, 0);
    endtask

    task automatic test_drain_pause();
        wait_for_drain();
        send_packet(8'($urandom), pick_motion(), pick_motion(), 0);
    endtask

    task automatic test_random_packets(input int byte_total);
        int sent;
        sent = 0;
        while (sent < byte_total)
        begin
            send_packet(8'($urandom), pick_motion(), pick_motion(), 12);
            sent += 3;
        end
    endtask

    initial
    begin
        byte_ch.valid <= 1'b0;
        byte_ch.status_byte <= 8'h00;
        byte_ch.data_byte <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_ignored_bytes();
        test_move_extremes();
        test_buttons();
        test_random_packets(RANDOM_BYTES / 2);
        test_drain_pause();
        test_random_packets(RANDOM_BYTES / 2);

        wait_for_drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("ps2_mouse_packet_decoder verification clean");
        else
            $display("ps2_mouse_packet_decoder verification failed");
        $finish;
    end

endmodule
